/* sv/ccr_pkg.sv */
// ----------------------------------------------------------------------------
// ccr_pkg: shared types and constants of the chunk completion tracker
// Holds the result status codes, the field widths and the divider result
// bundle that travels from the divider to the sequencer.
// ----------------------------------------------------------------------------
package ccr_pkg;

    // field widths
    localparam int SEQ_W   = 32;
    localparam int SIZE_W  = 16;
    localparam int TIME_W  = 64;
    localparam int CHUNK_W = 10;
    localparam int COUNT_W = 17;
    localparam int STAT_W  = 3;

    // function codes on s_tuser
    localparam logic FUNC_INJECT  = 1'b0;
    localparam logic FUNC_DELIVER = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_INJECTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_COUNTED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_COMPLETE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd3;
    localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd4;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd5;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd6;

    // delivered count saturates here
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    // divider result bundle
    typedef struct packed {
        logic              done;
        logic [SEQ_W-1:0]  quotient;
        logic [SIZE_W-1:0] remainder;
    } ccr_div_res_t;

endpackage

/* sv/ccr_div.sv */
// ----------------------------------------------------------------------------
// ccr_div: iterative restoring divider
// Divides a 32-bit sequence by a 16-bit nonzero chunk size, one quotient
// bit per cycle; done pulses for one cycle when quotient and remainder hold.
// ----------------------------------------------------------------------------
module ccr_div
    import ccr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SEQ_W-1:0]  dividend,
    input  logic [SIZE_W-1:0] divisor,
    output ccr_div_res_t      res
);

    logic [SEQ_W-1:0]  dq_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] dvs_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    // one trial subtraction per step
    logic [SIZE_W:0] trial;
    logic [SIZE_W:0] diff;
    logic            ge;

    assign trial = {rem_reg, dq_reg[SEQ_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[SEQ_W-2:0], ge};
            rem_reg <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = dq_reg;
    assign res.remainder = rem_reg;

endmodule

/* sv/ccr_table.sv */
// ----------------------------------------------------------------------------
// ccr_table: chunk table memories
// Start time and delivered count per chunk entry, one write address and one
// read address shared by both arrays, read data registered.
// ----------------------------------------------------------------------------
module ccr_table
    import ccr_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int IW    = 10
)
(
    input  logic               aclk,
    input  logic               start_we,
    input  logic               cnt_we,
    input  logic [IW-1:0]      waddr,
    input  logic [TIME_W-1:0]  start_wdata,
    input  logic [COUNT_W-1:0] cnt_wdata,
    input  logic [IW-1:0]      raddr,
    output logic [TIME_W-1:0]  start_rdata,
    output logic [COUNT_W-1:0] cnt_rdata
);

    logic [TIME_W-1:0]  start_mem [DEPTH];
    logic [COUNT_W-1:0] cnt_mem   [DEPTH];

    // start time array
    always_ff @(posedge aclk) begin
        if (start_we) begin
            start_mem[waddr] <= start_wdata;
        end
        start_rdata <= start_mem[raddr];
    end

    // delivered count array
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[waddr] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[raddr];
    end

endmodule

/* sv/chunk_completion_tracker.sv */
// ----------------------------------------------------------------------------
// chunk_completion_tracker: per-flow chunk completion tracking
// Hands out sequence numbers to injected packets, opens a table entry at each
// chunk boundary and counts deliveries per chunk, reporting chunk completion.
//
// Usage:
//   s_ channel: one word per request; s_tuser is the function (0 inject,
//   1 deliver), s_tdata carries the delivered sequence and the current time.
//   m_ channel: exactly one result word per request (status, assigned
//   sequence, chunk number, first injection time, completion time).
//   cfg_we/cfg_wdata write chunk_size; write only while the block is idle.
//   Flow: a deliver with tracking on runs the 32-step shared divider, then a
//   table read and update, then the output register; an inject or an unknown
//   delivery skips the update; requests answered without division go straight
//   to the output register. One request is in work at a time; s_tready is high
//   only when idle, so a new request waits until the last result is loaded.
//   A finished result sits in the output register; if the receiver stalls,
//   a new request is still taken, and its result waits until the previous
//   word is taken.
//   Reset clears the sequence counter, the open-entry count and chunk_size;
//   the table itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module chunk_completion_tracker
    import ccr_pkg::*;
#(
    parameter int MAX_CHUNKS = 1024
)
(
    input  logic          aclk,
    input  logic          aresetn,
    // config
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,     // chunk_size
    // request channel
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,       // packet_sequence[31:0], time_ps[95:32]
    input  logic          s_tuser,       // func
    // result channel
    output logic          m_tvalid,
    input  logic          m_tready,
    // status[2:0], assigned_sequence[34:3], chunk_number[44:35],
    // first_injection_ps[108:45], completion_time[172:109], zero fill[175:173]
    output logic [175:0]  m_tdata
);

    localparam int OW = $clog2(MAX_CHUNKS + 1);
    localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_UPDATE,
        S_FINISH
    } state_t;

    state_t              state_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [SEQ_W:0]      next_seq_reg;
    logic [OW-1:0]       opened_reg;
    logic                func_reg;
    logic [SEQ_W-1:0]    seq_in_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [IW-1:0]       idx_reg;
    logic [STAT_W-1:0]   res_status_reg;
    logic [SEQ_W-1:0]    res_aseq_reg;
    logic [CHUNK_W-1:0]  res_chunk_reg;
    logic [TIME_W-1:0]   res_first_reg;
    logic [TIME_W-1:0]   res_comp_reg;
    logic                m_tvalid_reg;
    logic [175:0]        m_tdata_reg;

    logic                accept;
    logic                div_start;
    logic [SEQ_W-1:0]    div_dividend;
    ccr_div_res_t        div_res;
    logic                tbl_full;
    logic                deliver_unknown;
    logic                start_we;
    logic                cnt_we;
    logic [IW-1:0]       waddr;
    logic [COUNT_W-1:0]  cnt_wdata;
    logic [TIME_W-1:0]   start_rdata;
    logic [COUNT_W-1:0]  cnt_rdata;
    logic [COUNT_W-1:0]  cnt_new;
    logic                out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // divider launch on an accepted word that needs a chunk index
    assign div_start = accept && (size_reg != '0) &&
                       ((s_tuser == FUNC_DELIVER) || !next_seq_reg[SEQ_W]);
    assign div_dividend = (s_tuser == FUNC_DELIVER) ? s_tdata[31:0]
                                                    : next_seq_reg[SEQ_W-1:0];

    ccr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (size_reg),
        .res      (div_res)
    );

    // decisions on the quotient
    assign tbl_full = opened_reg >= OW'(MAX_CHUNKS);
    assign deliver_unknown = (div_res.quotient >= SEQ_W'(opened_reg)) ||
                             ({1'b0, seq_in_reg} >= next_seq_reg);

    // saturating count bump
    assign cnt_new = (cnt_rdata == COUNT_MAX) ? cnt_rdata
                                              : cnt_rdata + COUNT_W'(1);

    // table write control
    always_comb begin
        start_we  = 1'b0;
        cnt_we    = 1'b0;
        waddr     = opened_reg[IW-1:0];
        cnt_wdata = '0;
        case (state_reg)
            S_DIVIDE: begin
                if (div_res.done && (func_reg == FUNC_INJECT) &&
                    (div_res.remainder == '0) && !tbl_full) begin
                    start_we = 1'b1;
                    cnt_we   = 1'b1;
                end
            end
            S_UPDATE: begin
                cnt_we    = 1'b1;
                waddr     = idx_reg;
                cnt_wdata = cnt_new;
            end
            default: begin
            end
        endcase
    end

    ccr_table #(
        .DEPTH (MAX_CHUNKS),
        .IW    (IW)
    ) u_table (
        .aclk        (aclk),
        .start_we    (start_we),
        .cnt_we      (cnt_we),
        .waddr       (waddr),
        .start_wdata (time_reg),
        .cnt_wdata   (cnt_wdata),
        .raddr       (div_res.quotient[IW-1:0]),
        .start_rdata (start_rdata),
        .cnt_rdata   (cnt_rdata)
    );

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= '0;
        end else if (cfg_we) begin
            size_reg <= cfg_wdata;
        end
    end

    // sequencer, flow state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            next_seq_reg <= '0;
            opened_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // word taken and no new one loaded this cycle
            if (m_tvalid_reg && m_tready && (state_reg != S_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        func_reg      <= s_tuser;
                        seq_in_reg    <= s_tdata[31:0];
                        time_reg      <= s_tdata[95:32];
                        res_chunk_reg <= '0;
                        res_first_reg <= '0;
                        res_comp_reg  <= '0;
                        if (div_start) begin
                            state_reg    <= S_DIVIDE;
                            res_aseq_reg <= '0;
                        end else begin
                            state_reg <= S_FINISH;
                            if (s_tuser == FUNC_DELIVER) begin
                                res_status_reg <= ST_IGNORED;
                                res_aseq_reg   <= '0;
                            end else if (next_seq_reg[SEQ_W]) begin
                                res_status_reg <= ST_EXHAUSTED;
                                res_aseq_reg   <= '0;
                            end else begin
                                // tracking off: sequence only
                                res_status_reg <= ST_INJECTED;
                                res_aseq_reg   <= next_seq_reg[SEQ_W-1:0];
                                next_seq_reg   <= next_seq_reg + (SEQ_W+1)'(1);
                            end
                        end
                    end
                end
                S_DIVIDE: begin
                    if (div_res.done) begin
                        idx_reg <= div_res.quotient[IW-1:0];
                        if (func_reg == FUNC_INJECT) begin
                            state_reg <= S_FINISH;
                            if ((div_res.remainder == '0) && tbl_full) begin
                                res_status_reg <= ST_FULL;
                            end else begin
                                res_status_reg <= ST_INJECTED;
                                res_aseq_reg   <= next_seq_reg[SEQ_W-1:0];
                                res_chunk_reg  <= div_res.quotient[CHUNK_W-1:0];
                                next_seq_reg   <= next_seq_reg + (SEQ_W+1)'(1);
                                if (div_res.remainder == '0) begin
                                    opened_reg <= opened_reg + OW'(1);
                                end
                            end
                        end else begin
                            res_chunk_reg <= div_res.quotient[CHUNK_W-1:0];
                            if (deliver_unknown) begin
                                res_status_reg <= ST_UNKNOWN;
                                state_reg      <= S_FINISH;
                            end else begin
                                state_reg <= S_UPDATE;
                            end
                        end
                    end
                end
                S_UPDATE: begin
                    state_reg <= S_FINISH;
                    if (cnt_new == {1'b0, size_reg}) begin
                        res_status_reg <= ST_COMPLETE;
                        res_first_reg  <= start_rdata;
                        res_comp_reg   <= time_reg;
                    end else begin
                        res_status_reg <= ST_COUNTED;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {3'b000, res_comp_reg, res_first_reg,
                                         res_chunk_reg, res_aseq_reg, res_status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // sequence counter only moves forward
    a_seq_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> next_seq_reg >= $past(next_seq_reg))
        else $error("sequence counter went backward");

    // open-entry count stays within the table
    a_opened_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        opened_reg <= OW'(MAX_CHUNKS))
        else $error("open-entry count beyond table depth");

    // divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> state_reg == S_DIVIDE)
        else $error("divider result outside divide state");

    // an entry is opened only by an inject that succeeds
    a_open_on_inject: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (opened_reg == $past(opened_reg)) ||
                 (res_status_reg == ST_INJECTED))
        else $error("entry opened without a successful inject");

endmodule
